### sv/tked_pkg.sv
// shared key codes, parse phases and lookup functions for the terminal key decoder
package tked_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned KeyW  = 6;
    localparam int unsigned PhW   = 3;
    localparam int unsigned ModW  = 2;
    localparam int unsigned ColW  = 3;

    typedef logic [ByteW-1:0] t_byte;
    typedef logic [KeyW-1:0]  t_key;
    typedef logic [PhW-1:0]   t_phase;
    typedef logic [ModW-1:0]  t_mod;
    typedef logic [ColW-1:0]  t_col;

    // decoder result for one input byte
    typedef struct packed {
        logic  emit;
        t_key  key_code;
        t_byte char_value;
    } t_key_result;

    // parse phases
    localparam t_phase PhIdle  = 3'd0;
    localparam t_phase PhEsc   = 3'd1;
    localparam t_phase PhCsi   = 3'd2;
    localparam t_phase PhDigit = 3'd3;
    localparam t_phase PhSemi  = 3'd4;
    localparam t_phase PhMod   = 3'd5;

    // modifier kinds
    localparam t_mod ModNone      = 2'd0;
    localparam t_mod ModShift     = 2'd1;
    localparam t_mod ModCtrl      = 2'd2;
    localparam t_mod ModShiftCtrl = 2'd3;

    // final letter columns
    localparam t_col ColUp      = 3'd0;
    localparam t_col ColDown    = 3'd1;
    localparam t_col ColRight   = 3'd2;
    localparam t_col ColLeft    = 3'd3;
    localparam t_col ColHome    = 3'd4;
    localparam t_col ColEnd     = 3'd5;
    localparam t_col ColUnknown = 3'd6;

    // special bytes
    localparam t_byte ByteEsc     = 8'd27;
    localparam t_byte ByteBracket = 8'd91;
    localparam t_byte ByteSemi    = 8'd59;
    localparam t_byte ByteTilde   = 8'd126;
    localparam t_byte ByteZero    = 8'd48;
    localparam t_byte ByteNine    = 8'd57;
    localparam t_byte ByteTwo     = 8'd50;
    localparam t_byte ByteFive    = 8'd53;
    localparam t_byte ByteSix     = 8'd54;

    // key codes
    localparam t_key KeyNone          = 6'd0;
    localparam t_key KeyChar          = 6'd1;
    localparam t_key KeyEnter         = 6'd2;
    localparam t_key KeyBackspace     = 6'd3;
    localparam t_key KeyDelete        = 6'd4;
    localparam t_key KeyTab           = 6'd5;
    localparam t_key KeyCtrlS         = 6'd6;
    localparam t_key KeyCtrlQ         = 6'd7;
    localparam t_key KeyCtrlB         = 6'd8;
    localparam t_key KeyCtrlR         = 6'd9;
    localparam t_key KeyUp            = 6'd10;
    localparam t_key KeyDown          = 6'd11;
    localparam t_key KeyLeft          = 6'd12;
    localparam t_key KeyRight         = 6'd13;
    localparam t_key KeyHome          = 6'd14;
    localparam t_key KeyEnd           = 6'd15;
    localparam t_key KeyPageUp        = 6'd16;
    localparam t_key KeyPageDown      = 6'd17;
    localparam t_key KeyCtrlHome      = 6'd18;
    localparam t_key KeyCtrlEnd       = 6'd19;
    localparam t_key KeyCtrlUp        = 6'd20;
    localparam t_key KeyCtrlDown      = 6'd21;
    localparam t_key KeyCtrlLeft      = 6'd22;
    localparam t_key KeyCtrlRight     = 6'd23;
    localparam t_key KeyShiftUp       = 6'd24;
    localparam t_key KeyShiftDown     = 6'd25;
    localparam t_key KeyShiftLeft     = 6'd26;
    localparam t_key KeyShiftRight    = 6'd27;
    localparam t_key KeyShiftHome     = 6'd28;
    localparam t_key KeyShiftEnd      = 6'd29;
    localparam t_key KeyShCtrlUp      = 6'd30;
    localparam t_key KeyShCtrlDown    = 6'd31;
    localparam t_key KeyShCtrlLeft    = 6'd32;
    localparam t_key KeyShCtrlRight   = 6'd33;
    localparam t_key KeyShCtrlHome    = 6'd34;
    localparam t_key KeyShCtrlEnd     = 6'd35;
    localparam t_key KeyCtrlC         = 6'd36;
    localparam t_key KeyCtrlX         = 6'd37;
    localparam t_key KeyCtrlV         = 6'd38;
    localparam t_key KeyCtrlZ         = 6'd39;
    localparam t_key KeyCtrlY         = 6'd40;

    function automatic t_col letter_col(input t_byte b);
        t_col col;
        unique case (b)
            8'd65:   col = ColUp;
            8'd66:   col = ColDown;
            8'd67:   col = ColRight;
            8'd68:   col = ColLeft;
            8'd72:   col = ColHome;
            8'd70:   col = ColEnd;
            default: col = ColUnknown;
        endcase
        return col;
    endfunction

    function automatic t_key lone_key(input t_byte b);
        t_key k;
        unique case (b)
            8'd3:    k = KeyCtrlC;
            8'd24:   k = KeyCtrlX;
            8'd22:   k = KeyCtrlV;
            8'd26:   k = KeyCtrlZ;
            8'd25:   k = KeyCtrlY;
            8'd19:   k = KeyCtrlS;
            8'd17:   k = KeyCtrlQ;
            8'd2:    k = KeyCtrlB;
            8'd18:   k = KeyCtrlR;
            8'd10:   k = KeyEnter;
            8'd127:  k = KeyBackspace;
            8'd9:    k = KeyTab;
            default: k = KeyChar;
        endcase
        return k;
    endfunction

    function automatic t_key tilde_key(input t_byte d);
        t_key k;
        unique case (d)
            8'd49:   k = KeyHome;
            8'd52:   k = KeyEnd;
            8'd53:   k = KeyPageUp;
            8'd54:   k = KeyPageDown;
            8'd51:   k = KeyDelete;
            default: k = KeyNone;
        endcase
        return k;
    endfunction

    function automatic t_key plain_key(input t_col col);
        t_key k;
        unique case (col)
            ColUp:    k = KeyUp;
            ColDown:  k = KeyDown;
            ColRight: k = KeyRight;
            ColLeft:  k = KeyLeft;
            ColHome:  k = KeyHome;
            ColEnd:   k = KeyEnd;
            default:  k = KeyNone;
        endcase
        return k;
    endfunction

    function automatic t_key mod_key(input t_mod kind, input t_col col);
        t_key k;
        k = KeyNone;
        unique case (kind)
            ModShift: begin
                unique case (col)
                    ColUp:    k = KeyShiftUp;
                    ColDown:  k = KeyShiftDown;
                    ColRight: k = KeyShiftRight;
                    ColLeft:  k = KeyShiftLeft;
                    ColHome:  k = KeyShiftHome;
                    ColEnd:   k = KeyShiftEnd;
                    default:  k = KeyNone;
                endcase
            end
            ModCtrl: begin
                unique case (col)
                    ColUp:    k = KeyCtrlUp;
                    ColDown:  k = KeyCtrlDown;
                    ColRight: k = KeyCtrlRight;
                    ColLeft:  k = KeyCtrlLeft;
                    ColHome:  k = KeyCtrlHome;
                    ColEnd:   k = KeyCtrlEnd;
                    default:  k = KeyNone;
                endcase
            end
            ModShiftCtrl: begin
                unique case (col)
                    ColUp:    k = KeyShCtrlUp;
                    ColDown:  k = KeyShCtrlDown;
                    ColRight: k = KeyShCtrlRight;
                    ColLeft:  k = KeyShCtrlLeft;
                    ColHome:  k = KeyShCtrlHome;
                    ColEnd:   k = KeyShCtrlEnd;
                    default:  k = KeyNone;
                endcase
            end
            default: k = KeyNone;
        endcase
        return k;
    endfunction

endpackage

### sv/tked_decode.sv
// escape sequence parser: parse state registers and per-byte key decode
module tked_decode (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  tked_pkg::t_byte       i_byte,
    output tked_pkg::t_key_result o_result
);
    import tked_pkg::*;

    t_phase r_phase, n_phase;
    t_byte  r_held,  n_held;
    t_mod   r_mod,   n_mod;
    t_col   col;

    assign col = letter_col(i_byte);

    always_comb begin
        n_phase             = PhIdle;
        n_held              = r_held;
        n_mod               = r_mod;
        o_result.emit       = 1'b1;
        o_result.key_code   = KeyNone;
        o_result.char_value = '0;
        unique case (r_phase)
            PhEsc: begin
                if (i_byte == ByteBracket) begin
                    n_phase       = PhCsi;
                    o_result.emit = 1'b0;
                end
            end
            PhCsi: begin
                if (i_byte >= ByteZero && i_byte <= ByteNine) begin
                    n_held        = i_byte;
                    n_phase       = PhDigit;
                    o_result.emit = 1'b0;
                end else begin
                    o_result.key_code = plain_key(col);
                end
            end
            PhDigit: begin
                if (i_byte == ByteSemi) begin
                    n_phase       = PhSemi;
                    o_result.emit = 1'b0;
                end else if (i_byte == ByteTilde) begin
                    o_result.key_code = tilde_key(r_held);
                end
            end
            PhSemi: begin
                priority if (i_byte == ByteTwo)  n_mod = ModShift;
                else if (i_byte == ByteFive)     n_mod = ModCtrl;
                else if (i_byte == ByteSix)      n_mod = ModShiftCtrl;
                else                             n_mod = ModNone;
                n_phase       = PhMod;
                o_result.emit = 1'b0;
            end
            PhMod: begin
                o_result.key_code = mod_key(r_mod, col);
            end
            // idle, and the unused phase codes
            default: begin
                if (i_byte == ByteEsc) begin
                    n_phase       = PhEsc;
                    o_result.emit = 1'b0;
                end else begin
                    o_result.key_code = lone_key(i_byte);
                    if (o_result.key_code == KeyChar) begin
                        o_result.char_value = i_byte;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PhIdle;
            r_held  <= '0;
            r_mod   <= ModNone;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_mod   <= n_mod;
        end
    end

endmodule

### sv/terminal_key_escape_decoder.sv
// top level: input byte register, escape parser and registered key result
//
//  channel   valid        ready        payload
//  input     i_in_valid   o_in_ready   i_in_byte
//  output    o_out_valid  i_out_ready  o_key_code, o_char_value
//
// one byte per cycle unless stalled; keys pass the byte, then the result register
// bytes that continue a sequence give no output transaction
// a full result register with i_out_ready low holds a byte that makes a key, and
// the input then stalls; the parse state advances only as a byte is consumed
// synchronous active-low reset returns the parser to idle and empties both registers
module terminal_key_escape_decoder (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  tked_pkg::t_byte       i_in_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output tked_pkg::t_key        o_key_code,
    output tked_pkg::t_byte       o_char_value
);
    import tked_pkg::*;

    logic        r_in_valid;
    t_byte       r_in_byte;
    logic        r_out_valid;
    t_key        r_key_code;
    t_byte       r_char_value;
    logic        out_free;
    logic        advance;
    t_key_result result;

    tked_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .o_result  (result)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    // the held byte moves on unless it makes a key with nowhere to go
    assign advance    = r_in_valid && (!result.emit || out_free);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && result.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && result.emit) begin
            r_key_code   <= result.key_code;
            r_char_value <= result.char_value;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_key_code   = r_key_code;
    assign o_char_value = r_char_value;

endmodule
